### rtl/alr_pkg.sv
package alr_pkg;

	localparam int COORD_INT_BITS = 10;
	localparam int FRAC_BITS = 8;
	localparam int SLOPE_FRAC = 16;
	localparam int PIX_W = 11;
	localparam int COV_W = 9;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_FAR  = 2'd1,
		PH_COLS = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_DIV   = 3'd1,
		ST_EP1   = 3'd2,
		ST_EP2   = 3'd3,
		ST_OUT0  = 3'd4,
		ST_OUT1  = 3'd5
	} seq_t;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

endpackage

### rtl/alr_div.sv
// Restoring divider: one quotient bit per cycle, unsigned.
module alr_div #(
	parameter int NUM_W = 34,
	parameter int DEN_W = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			// The quotient is complete the cycle after the last step.
			done_q <= busy_q && !start && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

### rtl/alr_endpoint.sv
// Endpoint rounding: column, minor position in Q.16 and the rounding fraction.
module alr_endpoint #(
	parameter int CIB = 10,
	parameter int FB  = 8
) (
	input  logic [CIB+FB-1:0]  px,
	input  logic [CIB+FB-1:0]  py,
	input  logic signed [19:0] grad,
	output logic [CIB:0]       xe,
	output logic signed [CIB+18:0] yq,
	output logic [FB-1:0]      fr
);
	localparam int CW = CIB + FB;
	localparam int SLOPE_SH = alr_pkg::SLOPE_FRAC - FB;
	logic [CW:0]           t;
	logic signed [FB+1:0]  dif;
	logic signed [FB+21:0] prod;
	logic signed [CIB+18:0] base;

	always_comb begin
		t    = {1'b0, px} + (CW+1)'(1 << (FB - 1));
		xe   = t[CW:FB];
		fr   = t[FB-1:0];
		// Offset is 0.5 minus the fraction, in the range (-0.5, 0.5].
		dif  = (FB+2)'(1 << (FB - 1)) - $signed({2'b00, fr});
		prod = grad * dif;
		base = $signed((CIB+19)'({1'b0, py}) << SLOPE_SH);
		yq   = base + (CIB+19)'(prod >>> FB);
	end
endmodule

### rtl/antialiased_line_rasterizer_top.sv
// Antialiased line rasterizer in fixed point. A start transaction (opcode 0)
// loads a segment and yields the two pixels of the first endpoint; each step
// transaction (opcode 1) yields the next pixel pair: first the far endpoint,
// then one column per step, with last set on the final pixel. The block works
// on one transaction at a time and is not ready until both pixels of the
// previous one have left. A start spends most of its time in the serial
// divider that finds the slope; a start whose endpoints share the major
// coordinate skips the divider. The block waits while the output is held
// off. A step with no line loaded yields nothing. Off-screen coordinates
// read as 2^COORD_INT_BITS.
module antialiased_line_rasterizer_top #(
	parameter int COORD_INT_BITS = alr_pkg::COORD_INT_BITS,
	parameter int FRAC_BITS      = alr_pkg::FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [17:0] start_x,
	input  logic [17:0] start_y,
	input  logic [17:0] end_x,
	input  logic [17:0] end_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] pixel_x,
	output logic [10:0] pixel_y,
	output logic [8:0]  coverage,
	output logic        last
);
	localparam int CW   = COORD_INT_BITS + FRAC_BITS;
	localparam int YW   = COORD_INT_BITS + 19;
	localparam int NW   = CW + 16;
	localparam int RW   = COORD_INT_BITS + 2;

	alr_pkg::seq_t   st_q, st_d;
	alr_pkg::phase_t ph_q;
	logic            steep_q;
	logic [CW-1:0]   x0_q, y0_q, x1_q, y1_q;
	logic            neg_q;
	logic signed [19:0] slope_q;
	logic signed [YW-1:0] icpt_q;
	logic signed [RW:0] col_q, lcol_q, frow_q, row_q;
	logic [7:0]      ffr_q, f_q;
	logic [8:0]      fgap_q, g_q;
	logic            full_q, done_q;
	logic            div_go_q;

	// Output register.
	logic            ov_q;
	logic [10:0]     ox_q, oy_q;
	logic [8:0]      oc_q;
	logic            ol_q;

	logic            acc;
	assign acc      = in_valid && in_ready;
	assign in_ready = (st_q == alr_pkg::ST_IDLE) && !ov_q;

	// Order and steep swap on the incoming transaction.
	logic [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	logic [CW-1:0] adx, ady;
	logic          stp;
	always_comb begin
		ax0 = start_x[CW-1:0]; ay0 = start_y[CW-1:0];
		ax1 = end_x[CW-1:0];   ay1 = end_y[CW-1:0];
		adx = (ax1 > ax0) ? ax1 - ax0 : ax0 - ax1;
		ady = (ay1 > ay0) ? ay1 - ay0 : ay0 - ay1;
		stp = ady > adx;
		bx0 = stp ? ay0 : ax0; by0 = stp ? ax0 : ay0;
		bx1 = stp ? ay1 : ax1; by1 = stp ? ax1 : ay1;
	end

	logic            dstart, ddone;
	logic [NW-1:0]   dquo;
	logic [CW-1:0]   ddx, ddy;
	assign ddx    = x1_q - x0_q;
	assign ddy    = (y1_q >= y0_q) ? y1_q - y0_q : y0_q - y1_q;
	// The divider is started once, in the first cycle after the start transaction, unless ddx is zero.
	assign dstart = div_go_q && (ddx != '0);

	alr_div #(.NUM_W(NW), .DEN_W(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart),
		.num({ddy, 16'd0}), .den(ddx), .done(ddone), .quo(dquo)
	);

	// One shared endpoint unit, used for each endpoint in turn.
	logic [CW-1:0]   epx, epy;
	logic [COORD_INT_BITS:0] exe;
	logic signed [YW-1:0] eyq;
	logic [FRAC_BITS-1:0] efr;
	assign epx = (st_q == alr_pkg::ST_EP1) ? x0_q : x1_q;
	assign epy = (st_q == alr_pkg::ST_EP1) ? y0_q : y1_q;

	alr_endpoint #(.CIB(COORD_INT_BITS), .FB(FRAC_BITS)) u_ep (
		.px(epx), .py(epy), .grad(slope_q), .xe(exe), .yq(eyq), .fr(efr)
	);

	function automatic logic [8:0] to_q8(input logic [FRAC_BITS:0] v);
		logic [FRAC_BITS+8:0] w;
		w = {8'd0, v} << 8;
		return 9'(w >> FRAC_BITS);
	endfunction

	function automatic logic [10:0] clampp(input logic signed [RW:0] v);
		if (v < 0 || v >= (RW+1)'(1 << COORD_INT_BITS)) begin
			return 11'(1 << COORD_INT_BITS);
		end
		return 11'(v);
	endfunction

	logic signed [RW:0] rowq;
	logic [8:0] g1;
	logic [16:0] cp0, cp1;
	logic signed [RW:0] prow, pcol;
	logic [8:0] pcov;
	logic       plast;
	always_comb begin
		rowq = (RW+1)'(eyq >>> 16);
		g1   = to_q8((FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, efr});
		cp0  = (17'd256 - {9'd0, f_q}) * {8'd0, g_q};
		cp1  = {9'd0, f_q} * {8'd0, g_q};
		pcol = col_q;
		if (st_q == alr_pkg::ST_OUT0) begin
			prow  = row_q;
			pcov  = full_q ? 9'(9'd256 - {1'b0, f_q}) : cp0[16:8];
			plast = 1'b0;
		end else begin
			prow  = row_q + 1'b1;
			pcov  = full_q ? {1'b0, f_q} : cp1[16:8];
			plast = done_q;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			alr_pkg::ST_IDLE: begin
				if (acc && opcode == alr_pkg::OP_START) begin
					st_d = alr_pkg::ST_DIV;
				end else if (acc && ph_q != alr_pkg::PH_IDLE) begin
					st_d = alr_pkg::ST_OUT0;
				end
			end
			alr_pkg::ST_DIV:  if (ddone || ddx == '0) st_d = alr_pkg::ST_EP1;
			alr_pkg::ST_EP1:  st_d = alr_pkg::ST_EP2;
			alr_pkg::ST_EP2:  st_d = alr_pkg::ST_OUT0;
			alr_pkg::ST_OUT0: if (!ov_q) st_d = alr_pkg::ST_OUT1;
			alr_pkg::ST_OUT1: if (!ov_q) st_d = alr_pkg::ST_IDLE;
			default:          st_d = alr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= alr_pkg::ST_IDLE;
			ph_q     <= alr_pkg::PH_IDLE;
			done_q   <= 1'b0;
			ov_q     <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			st_q <= st_d;
			div_go_q <= acc && (opcode == alr_pkg::OP_START);
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (st_q)
				alr_pkg::ST_IDLE: begin
					done_q <= 1'b0;
					if (acc && opcode == alr_pkg::OP_START) begin
						ph_q <= alr_pkg::PH_IDLE;
					end else if (acc && ph_q == alr_pkg::PH_FAR) begin
						done_q <= (col_q + 1'b1 >= lcol_q);
						ph_q   <= (col_q + 1'b1 >= lcol_q) ? alr_pkg::PH_IDLE : alr_pkg::PH_COLS;
					end else if (acc && ph_q == alr_pkg::PH_COLS) begin
						done_q <= (col_q + 2'd2 >= lcol_q);
						if (col_q + 2'd2 >= lcol_q) ph_q <= alr_pkg::PH_IDLE;
					end
				end
				alr_pkg::ST_EP2: ph_q <= alr_pkg::PH_FAR;
				alr_pkg::ST_OUT0, alr_pkg::ST_OUT1: begin
					if (!ov_q) ov_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (!ov_q && (st_q == alr_pkg::ST_OUT0 || st_q == alr_pkg::ST_OUT1)) begin
			ox_q <= steep_q ? clampp(prow) : clampp(pcol);
			oy_q <= steep_q ? clampp(pcol) : clampp(prow);
			oc_q <= pcov;
			ol_q <= plast;
		end
		case (st_q)
			alr_pkg::ST_IDLE: begin
				if (acc && opcode == alr_pkg::OP_START) begin
					steep_q <= stp;
					if (bx0 > bx1) begin
						x0_q <= bx1; y0_q <= by1; x1_q <= bx0; y1_q <= by0;
						neg_q <= by1 > by0;
					end else begin
						x0_q <= bx0; y0_q <= by0; x1_q <= bx1; y1_q <= by1;
						neg_q <= by0 > by1;
					end
				end else if (acc && ph_q == alr_pkg::PH_FAR) begin
					col_q  <= lcol_q;
					row_q  <= frow_q;
					f_q    <= ffr_q;
					g_q    <= fgap_q;
					full_q <= 1'b0;
					// The first column waits in lcol_q and the last one in frow_q
					// until the far pair is out.
					lcol_q <= col_q;
					frow_q <= lcol_q;
				end else if (acc && ph_q == alr_pkg::PH_COLS) begin
					row_q  <= (RW+1)'(icpt_q >>> 16);
					f_q    <= icpt_q[15:8];
					full_q <= 1'b1;
					icpt_q <= icpt_q + YW'(slope_q);
					col_q  <= col_q + 1'b1;
				end
			end
			alr_pkg::ST_DIV: begin
				if (ddx == '0) begin
					slope_q <= 20'sd65536;
				end else if (ddone) begin
					slope_q <= neg_q ? -$signed(20'(dquo)) : $signed(20'(dquo));
				end
			end
			alr_pkg::ST_EP1: begin
				row_q  <= rowq;
				f_q    <= eyq[15:8];
				g_q    <= g1;
				full_q <= 1'b0;
				icpt_q <= eyq + YW'(slope_q);
				col_q  <= (RW+1)'(exe);
			end
			alr_pkg::ST_EP2: begin
				lcol_q <= (RW+1)'(exe);
				frow_q <= rowq;
				ffr_q  <= eyq[15:8];
				fgap_q <= to_q8({1'b0, efr});
			end
			alr_pkg::ST_OUT1: begin
				if (!ov_q && ph_q == alr_pkg::PH_COLS && full_q == 1'b0 && frow_q == col_q) begin
					col_q  <= lcol_q;
					lcol_q <= frow_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = ov_q;
	assign pixel_x   = ox_q;
	assign pixel_y   = oy_q;
	assign coverage  = oc_q;
	assign last      = ol_q;
endmodule
